>>> rtl/fpm_pkg.sv
// Shared types, constants and helpers for the binary64 multiplier pipeline.
// No dependencies; imported by fp64_multiplier_top and its testbench.
package fpm_pkg;

  localparam int unsigned NumStages = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [62:0] INF_MAG      = 63'h7FF0_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN  = 64'h7FF8_0000_0000_0000;
  localparam logic [12:0] EXP_BIAS_ADJ = 13'd1022;
  localparam logic signed [12:0] EXP_MAX = 13'sd2047;
  localparam logic [10:0] ROUND_HALF   = 11'h400;

  // Per-item information that travels alongside the datapath.
  typedef struct packed {
    logic        op;
    logic        sign;
    logic        spec;
    logic [63:0] spec_val;
  } tag_t;

  // Position of the most significant set bit of a fraction field.
  function automatic logic [5:0] msb_pos(input logic [51:0] frac);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 52; i++) begin
      if (frac[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> rtl/fp64_multiplier_top.sv
// IEEE 754 binary64 multiplier with a stored last product, as an 8-stage pipeline.
// Depends on fpm_pkg.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_ready    operation, operand_a, operand_b
//   output   out        out_valid / out_ready  product
//
// Every transfer passes through eight register stages, stage 0 to stage 7;
// one new item is taken every cycle while the output is not stalled.
// The 27x27-bit partial product stage and the 106-bit sum that follows it
// each own a stage of their own.
// Each stage moves forward when it is empty or the stage after it moves, so
// bubbles close up and a stalled output still lets the earlier stages fill.
// Reset (rst, synchronous) empties all stages and clears the stored product.
module fp64_multiplier_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] product
);
  import fpm_pkg::*;

  // Stage occupancy and the advance chain. A stage takes a new item when it
  // is empty or when its current item moves on this cycle.
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] rdy;

  always_comb begin
    rdy[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 0: the input register.
  logic        s0_op;
  logic [63:0] s0_a;
  logic [63:0] s0_b;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_op <= operation;
      s0_a  <= operand_a;
      s0_b  <= operand_b;
    end
  end

  // Stage 1: classify operands, resolve the special cases, and find the
  // left shift that normalizes a subnormal fraction.
  logic [10:0] ea_raw, eb_raw;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  tag_t        tag_in;
  logic [5:0]  sha_next, shb_next;

  assign ea_raw = s0_a[62:52];
  assign eb_raw = s0_b[62:52];
  assign fa     = s0_a[51:0];
  assign fb     = s0_b[51:0];
  assign sgn    = s0_a[63] ^ s0_b[63];
  assign a_nan  = (ea_raw == EXP_ALL_ONES) && (fa != '0);
  assign b_nan  = (eb_raw == EXP_ALL_ONES) && (fb != '0);
  assign a_inf  = (ea_raw == EXP_ALL_ONES) && (fa == '0);
  assign b_inf  = (eb_raw == EXP_ALL_ONES) && (fb == '0);
  assign a_zero = (ea_raw == '0) && (fa == '0);
  assign b_zero = (eb_raw == '0) && (fb == '0);

  always_comb begin
    tag_in.op       = s0_op;
    tag_in.sign     = sgn;
    tag_in.spec     = 1'b1;
    tag_in.spec_val = '0;
    if (a_nan) begin
      tag_in.spec_val = s0_a | QUIET_BIT;
    end else if (b_nan) begin
      tag_in.spec_val = s0_b | QUIET_BIT;
    end else if (a_inf || b_inf) begin
      tag_in.spec_val = (a_zero || b_zero) ? DEFAULT_NAN : {sgn, INF_MAG};
    end else if (a_zero || b_zero) begin
      tag_in.spec_val = {sgn, 63'd0};
    end else begin
      tag_in.spec = 1'b0;
    end
    sha_next = (ea_raw == '0) ? 6'(6'd52 - msb_pos(fa)) : '0;
    shb_next = (eb_raw == '0) ? 6'(6'd52 - msb_pos(fb)) : '0;
  end

  tag_t        s1_tag;
  logic [10:0] s1_ea, s1_eb;
  logic [51:0] s1_fa, s1_fb;
  logic [5:0]  s1_sha, s1_shb;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_tag <= tag_in;
      s1_ea  <= ea_raw;
      s1_eb  <= eb_raw;
      s1_fa  <= fa;
      s1_fb  <= fb;
      s1_sha <= sha_next;
      s1_shb <= shb_next;
    end
  end

  // Stage 2: normalized 53-bit significands and their biased exponents, below one for subnormals.
  tag_t               s2_tag;
  logic [52:0]        s2_ma, s2_mb;
  logic signed [12:0] s2_ea, s2_eb;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_tag <= s1_tag;
      s2_ma  <= {(s1_ea != '0), s1_fa} << s1_sha;
      s2_mb  <= {(s1_eb != '0), s1_fb} << s1_shb;
      s2_ea  <= (s1_ea != '0) ? $signed({2'b00, s1_ea}) : $signed(13'd1 - 13'(s1_sha));
      s2_eb  <= (s1_eb != '0) ? $signed({2'b00, s1_eb}) : $signed(13'd1 - 13'(s1_shb));
    end
  end

  // Stage 3: four partial products, each at most 27 by 27 bits.
  tag_t               s3_tag;
  logic [53:0]        s3_hh;
  logic [52:0]        s3_hl, s3_lh;
  logic [51:0]        s3_ll;
  logic signed [12:0] s3_e;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_tag <= s2_tag;
      s3_hh  <= 54'(s2_ma[52:26]) * 54'(s2_mb[52:26]);
      s3_hl  <= 53'(s2_ma[52:26]) * 53'(s2_mb[25:0]);
      s3_lh  <= 53'(s2_ma[25:0]) * 53'(s2_mb[52:26]);
      s3_ll  <= 52'(s2_ma[25:0]) * 52'(s2_mb[25:0]);
      s3_e   <= s2_ea + s2_eb - $signed(EXP_BIAS_ADJ);
    end
  end

  // Stage 4: the full 106-bit significand product.
  tag_t               s4_tag;
  logic [105:0]       s4_prod;
  logic signed [12:0] s4_e;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_tag  <= s3_tag;
      s4_prod <= {s3_hh, 52'd0} + {27'd0, s3_hl, 26'd0} + {27'd0, s3_lh, 26'd0}
               + {54'd0, s3_ll};
      s4_e    <= s3_e;
    end
  end

  // Stage 5: bring the leading one to the top and fold the low bits into a sticky bit.
  logic [105:0] prod_norm;

  assign prod_norm = s4_prod[105] ? s4_prod : {s4_prod[104:0], 1'b0};

  tag_t               s5_tag;
  logic [63:0]        s5_sig;
  logic signed [12:0] s5_e;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_tag <= s4_tag;
      s5_sig <= {prod_norm[105:43], prod_norm[42] | (prod_norm[41:0] != '0)};
      s5_e   <= s4_prod[105] ? s4_e : s4_e - 13'sd1;
    end
  end

  // Stage 6: overflow detection and the denormalizing shift for tiny results.
  logic [12:0] dn_sh;
  logic [63:0] jam_mask;
  logic [63:0] sig_next;
  logic [10:0] base_next;

  always_comb begin
    dn_sh    = 13'(13'sd1 - s5_e);
    jam_mask = (64'd1 << dn_sh[5:0]) - 64'd1;
    if (s5_e > 13'sd0) begin
      sig_next  = s5_sig;
      base_next = 11'(s5_e - 13'sd1);
    end else if (dn_sh >= 13'd64) begin
      sig_next  = {63'd0, (s5_sig != '0)};
      base_next = '0;
    end else begin
      sig_next  = (s5_sig >> dn_sh[5:0]) | {63'd0, ((s5_sig & jam_mask) != '0)};
      base_next = '0;
    end
  end

  tag_t        s6_tag;
  logic [63:0] s6_sig;
  logic [10:0] s6_base;
  logic        s6_ovf;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_tag  <= s5_tag;
      s6_sig  <= sig_next;
      s6_base <= base_next;
      s6_ovf  <= (s5_e >= EXP_MAX);
    end
  end

  // Stage 7: round to nearest even, pack, and pick the special result if any.
  // A read takes the stored product; every earlier write has already passed
  // this stage, so the stored value is the one the read should see.
  logic [52:0] mant;
  logic [10:0] rem;
  logic        round_up;
  logic [63:0] packed_sum;
  logic [63:0] mul_result;
  logic [63:0] last_product;

  always_comb begin
    mant       = s6_sig[63:11];
    rem        = s6_sig[10:0];
    round_up   = (rem > ROUND_HALF) || ((rem == ROUND_HALF) && mant[0]);
    packed_sum = {1'b0, s6_base, 52'd0} + {11'd0, mant} + {63'd0, round_up};
    if (s6_tag.spec) begin
      mul_result = s6_tag.spec_val;
    end else if (s6_ovf) begin
      mul_result = {s6_tag.sign, INF_MAG};
    end else begin
      mul_result = {s6_tag.sign, packed_sum[62:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_product <= '0;
    end else if (vld[6] && rdy[7] && (s6_tag.op == OP_WRITE)) begin
      last_product <= mul_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      product <= (s6_tag.op == OP_READ) ? last_product : mul_result;
    end
  end

  // With the output stage empty, the advance chain must open all the way back.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  // A result entering the output stage must agree with the stored product.
  a_product_matches_store: assert property (@(posedge clk) disable iff (rst)
    vld[6] && rdy[7] |=> product == last_product)
    else $error("output product differs from the stored product");

  // Reset leaves no result pending.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule

>>> dv/fp64_multiplier_top_tb.sv
// Self-checking testbench for the binary64 multiplier with a stored last product.
// Depends on fpm_pkg and fp64_multiplier_top; predicts every product and checks
// the transfers in order.
`timescale 1ns / 100ps

module fp64_multiplier_top_tb;
  import fpm_pkg::*;

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned MaxGap      = 10;
  localparam int unsigned MaxReported = 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] product;

  fp64_multiplier_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .product   (product)
  );

  // Bit-exact binary64 product with round-to-nearest-even. The significand
  // product is formed at full 106-bit width, so nothing is lost before rounding.
  function automatic logic [63:0] mul_binary64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0]  sign;
    int           ea;
    int           eb;
    int           e;
    int           sh;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [105:0] full;
    logic [63:0]  sig;
    logic [63:0]  base;
    logic [63:0]  mant;
    logic [10:0]  rem;
    logic         a_zero;
    logic         b_zero;
    sign   = (a ^ b) & 64'h8000_0000_0000_0000;
    ea     = int'(a[62:52]);
    eb     = int'(b[62:52]);
    ma     = {12'b0, a[51:0]};
    mb     = {12'b0, b[51:0]};
    a_zero = (ea == 0) && (ma == 0);
    b_zero = (eb == 0) && (mb == 0);
    // A NaN on the first operand wins over one on the second; both come back quiet.
    if (a[62:52] == EXP_ALL_ONES && ma != 0) return a | QUIET_BIT;
    if (b[62:52] == EXP_ALL_ONES && mb != 0) return b | QUIET_BIT;
    if (a[62:52] == EXP_ALL_ONES || b[62:52] == EXP_ALL_ONES) begin
      if (a_zero || b_zero) return DEFAULT_NAN;
      return sign | {1'b0, INF_MAG};
    end
    if (a_zero || b_zero) return sign;
    // Subnormals are normalized so that both significands carry the hidden bit.
    if (ea == 0) begin
      ea = 1;
      while (!ma[52]) begin
        ma = ma << 1;
        ea--;
      end
    end else begin
      ma[52] = 1'b1;
    end
    if (eb == 0) begin
      eb = 1;
      while (!mb[52]) begin
        mb = mb << 1;
        eb--;
      end
    end else begin
      mb[52] = 1'b1;
    end
    full = 106'(ma[52:0]) * 106'(mb[52:0]);
    e = ea + eb - 1022;
    if (!full[105]) begin
      full = full << 1;
      e--;
    end
    sig = full[105:42];
    if (full[41:0] != 0) sig[0] = 1'b1;
    if (e >= int'(EXP_MAX)) return sign | {1'b0, INF_MAG};
    if (e <= 0) begin
      // Denormalize, keeping every lost bit as a sticky bit.
      sh = 1 - e;
      if (sh >= 64) begin
        sig = (sig != 0) ? 64'd1 : 64'd0;
      end else begin
        sig = (sig >> sh) | 64'((sig & ((64'd1 << sh) - 64'd1)) != 0);
      end
      base = '0;
    end else begin
      base = 64'(e - 1) << 52;
    end
    mant = sig >> 11;
    rem  = sig[10:0];
    if (rem > ROUND_HALF || (rem == ROUND_HALF && mant[0])) mant++;
    return sign | (base + mant);
  endfunction

  // Keeps the stored product as the block sees it and the products in flight.
  class product_scoreboard;
    logic [63:0] stored_product;
    logic [63:0] pending_products[$];
    int unsigned mismatches;

    function new();
      stored_product = '0;
      mismatches     = 0;
    endfunction

    function void note_input(logic op, logic [63:0] a, logic [63:0] b);
      if (op == OP_WRITE) stored_product = mul_binary64(a, b);
      pending_products.push_back(stored_product);
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] want;
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("Unexpected product transfer: %h", got);
        return;
      end
      want = pending_products.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("Product mismatch: expected %h, actual %h", want, got);
      end
    endfunction
  endclass

  product_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one item after a random gap and holds it until it is taken.
  task automatic send_item(input logic op, input logic [63:0] a, input logic [63:0] b);
    int unsigned gap;
    gap = $urandom_range(MaxGap, 0);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    forever begin
      @(posedge clk);
      if (in_valid && in_ready) break;
    end
    sb.note_input(op, a, b);
  endtask

  // Draws an operand that lands in an interesting part of the number line:
  // specials, subnormals, and exponents near the bias and near the overflow and underflow edges.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7, 0))
      0: v[62:52] = 11'd0;
      1: v[62:52] = EXP_ALL_ONES;
      2: v[62:0]  = ($urandom_range(1, 0) == 0) ? 63'd0 : {1'b0, INF_MAG};
      3: v[62:52] = 11'($urandom_range(60, 1));
      4: v[62:52] = 11'($urandom_range(2046, 1990));
      5: v[62:52] = 11'($urandom_range(1060, 990));
      6: v[51:0]  = ($urandom_range(1, 0) == 0) ? 52'd0 : 52'($urandom_range(3, 1));
      default: ;
    endcase
    return v;
  endfunction

  // The output side takes products after a random stall each.
  initial begin : result_side
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(MaxGap, 0);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid && out_ready) break;
      end
      sb.check_result(product);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [63:0] a;
    logic [63:0] b;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_WRITE;
    operand_a = '0;
    operand_b = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: read after reset, each special case, and the field extremes.
    send_item(OP_READ, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_WRITE, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_item(OP_READ, 64'd0, 64'd0);
    send_item(OP_WRITE, 64'h7FF0_0000_0000_0001, 64'h7FF8_0000_0000_0002);
    send_item(OP_WRITE, 64'h3FF0_0000_0000_0000, 64'hFFF4_0000_0000_0000);
    send_item(OP_WRITE, 64'h7FF0_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_item(OP_WRITE, 64'hFFF0_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_item(OP_WRITE, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_item(OP_WRITE, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
    send_item(OP_WRITE, 64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000);
    send_item(OP_WRITE, 64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0001);
    send_item(OP_WRITE, 64'h0000_0000_0000_0003, 64'h3FE0_0000_0000_0000);
    send_item(OP_WRITE, 64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001);
    send_item(OP_WRITE, 64'h0010_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF);
    send_item(OP_WRITE, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001);
    send_item(OP_WRITE, 64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0001);
    send_item(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
    send_item(OP_READ, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321);
    send_item(OP_WRITE, 64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
    send_item(OP_WRITE, 64'h7FE0_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_item(OP_READ, 64'd0, 64'd0);

    // Random: mostly multiplies on shaped operands, with reads mixed in.
    for (int i = 0; i < RandomItems; i++) begin
      a = pick_operand();
      b = pick_operand();
      send_item(($urandom_range(5, 0) == 0) ? OP_READ : OP_WRITE, a, b);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
